// File: rtl/pfc_pkg.sv
package pfc_pkg;

    localparam logic [2:0] FMT_A1R5G5B5 = 3'd0;
    localparam logic [2:0] FMT_B8G8R8   = 3'd1;
    localparam logic [2:0] FMT_B8G8R8A8 = 3'd2;
    localparam logic [2:0] FMT_LUM8     = 3'd3;
    localparam logic [2:0] FMT_R4G4B4A4 = 3'd4;
    localparam logic [2:0] FMT_R5G5B5   = 3'd5;
    localparam logic [2:0] FMT_R5G6B5   = 3'd6;
    localparam logic [2:0] FMT_R8G8B8A8 = 3'd7;

    localparam logic [1:0] PAL_DIRECT = 2'd0;
    localparam logic [1:0] PAL_IDX4   = 2'd1;
    localparam logic [1:0] PAL_IDX8   = 2'd2;

    localparam logic [1:0] REG_SRC_FMT   = 2'd0;
    localparam logic [1:0] REG_DST_FMT   = 2'd1;
    localparam logic [1:0] REG_PAL_MODE  = 2'd2;
    localparam logic [1:0] REG_ALPHA_EN  = 2'd3;

    localparam int CFG_AW  = 4;
    localparam int RECIP_SHIFT = 24;

    localparam logic [1:0] CH_ALPHA = 2'd3;

    // lsb position of R, G, B, A per format
    localparam logic [4:0] FMT_POS [8][4] = '{
        '{5'd1,  5'd6,  5'd11, 5'd0},
        '{5'd16, 5'd8,  5'd0,  5'd0},
        '{5'd16, 5'd8,  5'd0,  5'd24},
        '{5'd0,  5'd0,  5'd0,  5'd0},
        '{5'd0,  5'd4,  5'd8,  5'd12},
        '{5'd0,  5'd5,  5'd10, 5'd0},
        '{5'd11, 5'd5,  5'd0,  5'd0},
        '{5'd0,  5'd8,  5'd16, 5'd24}
    };

    // field width of R, G, B, A per format
    localparam logic [3:0] FMT_WID [8][4] = '{
        '{4'd5, 4'd5, 4'd5, 4'd1},
        '{4'd8, 4'd8, 4'd8, 4'd0},
        '{4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd0},
        '{4'd4, 4'd4, 4'd4, 4'd4},
        '{4'd5, 4'd5, 4'd5, 4'd0},
        '{4'd5, 4'd6, 4'd5, 4'd0},
        '{4'd8, 4'd8, 4'd8, 4'd8}
    };

    localparam logic [2:0] FMT_BYTES [8] = '{
        3'd2, 3'd4, 3'd4, 3'd1, 3'd2, 3'd2, 3'd2, 3'd4
    };

    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_idx;
        logic [31:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_idx;
    } t_pal_req;

    function automatic logic [7:0] field_max(input logic [3:0] w);
        logic [8:0] m;
        m = (9'd1 << w) - 9'd1;
        return m[7:0];
    endfunction

    // just above 2^24 / (2^w - 1); exact quotient for every product c*omax in range
    function automatic logic [24:0] recip(input logic [3:0] w);
        logic [24:0] m;
        case (w)
            4'd4:    m = 25'd1118720;
            4'd5:    m = 25'd541248;
            4'd6:    m = 25'd266320;
            4'd8:    m = 25'd65794;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/pixel_format_converter.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------
// input    | i_in_valid / o_in_ready    | i_mode, i_palette_index, i_data_word
// output   | o_out_valid / i_out_ready  | o_out_pixel, o_out_bytes
// config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One transfer per cycle while o_in_ready is high; four register stages (capture and palette
// read, extract and scale multiply, reciprocal divide, pack) carry each pixel to o_out_valid.
// Palette writes give no result.
// Synchronous active-low reset clears the stage valids and sets the config registers to their defaults.
// Each stage holds while the next is full and stalled; bubbles close up.
module pixel_format_converter
    import pfc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_palette_index,
    input  logic [31:0]       i_data_word,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_out_pixel,
    output logic [2:0]        o_out_bytes,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [2:0] r_src_fmt;
    logic [2:0] r_dst_fmt;
    logic [1:0] r_pal_mode;
    logic       r_alpha_en;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt  <= FMT_R8G8B8A8;
            r_dst_fmt  <= FMT_R8G8B8A8;
            r_pal_mode <= PAL_DIRECT;
            r_alpha_en <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SRC_FMT:  r_src_fmt  <= pwdata[2:0];
                REG_DST_FMT:  r_dst_fmt  <= pwdata[2:0];
                REG_PAL_MODE: r_pal_mode <= pwdata[1:0];
                REG_ALPHA_EN: r_alpha_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SRC_FMT:  prdata = {29'd0, r_src_fmt};
            REG_DST_FMT:  prdata = {29'd0, r_dst_fmt};
            REG_PAL_MODE: prdata = {30'd0, r_pal_mode};
            REG_ALPHA_EN: prdata = {31'd0, r_alpha_en};
            default:      prdata = 32'd0;
        endcase
    end

    // stage control
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_xfer;

    assign rdy4 = !r_s4_valid || i_out_ready;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;
    assign o_in_ready = rdy1;
    assign in_xfer = i_in_valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= in_xfer && i_mode;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
            if (rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    // stage 1: capture, palette read
    t_pal_req    pal_req;
    logic [31:0] pal_data;
    logic        pal_ok;
    logic        use_pal;

    assign use_pal = r_pal_mode inside {PAL_IDX4, PAL_IDX8};

    always_comb begin
        pal_req.wr_en   = in_xfer && !i_mode;
        pal_req.wr_idx  = i_palette_index;
        pal_req.wr_data = i_data_word;
        pal_req.rd_en   = rdy1;
        pal_req.rd_idx  = (r_pal_mode == PAL_IDX4) ? {4'd0, i_data_word[3:0]}
                                                   : i_data_word[7:0];
    end

    pfc_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_req     (pal_req),
        .o_rd_data (pal_data),
        .o_rd_ok   (pal_ok)
    );

    logic [31:0] r_s1_word;
    logic [2:0]  r_s1_sf;
    logic [2:0]  r_s1_df;
    logic        r_s1_pal;
    logic        r_s1_pass;
    logic        r_s1_aen;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_word <= i_data_word;
            r_s1_sf   <= use_pal ? FMT_R8G8B8A8 : r_src_fmt;
            r_s1_df   <= r_dst_fmt;
            r_s1_pal  <= use_pal;
            r_s1_pass <= !use_pal && (r_src_fmt == r_dst_fmt);
            r_s1_aen  <= r_alpha_en;
        end
    end

    // stage 2: extract channels, multiply by destination max
    logic [31:0] s2_pixel;
    logic [15:0] n_s2_prod [4];
    logic [3:0]  n_s2_iw [4];
    logic [31:0] n_s2_word;

    assign s2_pixel = r_s1_pal ? (pal_ok ? pal_data : 32'd0) : r_s1_word;

    always_comb begin
        logic [3:0]  iw;
        logic [3:0]  ow;
        logic [7:0]  imax;
        logic [7:0]  omax;
        logic [7:0]  c;
        logic [31:0] sh;
        logic        force_max;
        for (int ch = 0; ch < 4; ch++) begin
            iw   = FMT_WID[r_s1_sf][ch];
            ow   = FMT_WID[r_s1_df][ch];
            imax = field_max(iw);
            omax = field_max(ow);
            sh   = s2_pixel >> FMT_POS[r_s1_sf][ch];
            c    = sh[7:0] & imax;
            force_max = (2'(ch) == CH_ALPHA) && (!r_s1_aen || iw == 4'd0);
            if (force_max) begin
                n_s2_prod[ch] = {8'd0, omax};
                n_s2_iw[ch]   = 4'd1;
            end else begin
                n_s2_prod[ch] = 16'(c) * 16'(omax);
                n_s2_iw[ch]   = iw;
            end
        end
        case (FMT_BYTES[r_s1_df])
            3'd1:    n_s2_word = {24'd0, r_s1_word[7:0]};
            3'd2:    n_s2_word = {16'd0, r_s1_word[15:0]};
            default: n_s2_word = r_s1_word;
        endcase
    end

    logic [15:0] r_s2_prod [4];
    logic [3:0]  r_s2_iw [4];
    logic [31:0] r_s2_word;
    logic [2:0]  r_s2_df;
    logic        r_s2_pass;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_s2_prod[ch] <= n_s2_prod[ch];
                r_s2_iw[ch]   <= n_s2_iw[ch];
            end
            r_s2_word <= n_s2_word;
            r_s2_df   <= r_s1_df;
            r_s2_pass <= r_s1_pass;
        end
    end

    // stage 3: divide by source max through reciprocal multiply
    logic [7:0] n_s3_q [4];

    always_comb begin
        logic [40:0] full;
        for (int ch = 0; ch < 4; ch++) begin
            full = 41'(r_s2_prod[ch]) * 41'(recip(r_s2_iw[ch]));
            n_s3_q[ch] = full[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    logic [7:0]  r_s3_q [4];
    logic [31:0] r_s3_word;
    logic [2:0]  r_s3_df;
    logic        r_s3_pass;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_s3_q[ch] <= n_s3_q[ch];
            end
            r_s3_word <= r_s2_word;
            r_s3_df   <= r_s2_df;
            r_s3_pass <= r_s2_pass;
        end
    end

    // stage 4: pack into destination fields, or pass the word through when formats match
    logic [31:0] n_s4_pixel;

    always_comb begin
        logic [7:0] omax;
        n_s4_pixel = 32'd0;
        for (int ch = 0; ch < 4; ch++) begin
            omax = field_max(FMT_WID[r_s3_df][ch]);
            n_s4_pixel = n_s4_pixel | (32'(r_s3_q[ch] & omax) << FMT_POS[r_s3_df][ch]);
        end
        if (r_s3_pass) begin
            n_s4_pixel = r_s3_word;
        end
    end

    logic [31:0] r_s4_pixel;
    logic [2:0]  r_s4_bytes;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_pixel <= n_s4_pixel;
            r_s4_bytes <= FMT_BYTES[r_s3_df];
        end
    end

    assign o_out_valid = r_s4_valid;
    assign o_out_pixel = r_s4_pixel;
    assign o_out_bytes = r_s4_bytes;

    a_pal_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_mode |=> !r_s1_valid)
        else $error("palette write entered the pipeline");

    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_mode |=> r_s1_valid)
        else $error("accepted pixel lost at stage 1");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !rdy3 |=> r_s2_valid)
        else $error("stalled stage 2 item dropped");

    a_bytes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_bytes == 3'd1 || o_out_bytes == 3'd2 ||
                         o_out_bytes == 3'd4))
        else $error("illegal byte count");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_bytes == 3'd2 |-> o_out_pixel[31:16] == 16'd0)
        else $error("bits beyond destination width set");

endmodule

// File: rtl/pfc_palette.sv
module pfc_palette
    import pfc_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  t_pal_req    i_req,
    output logic [31:0] o_rd_data,
    output logic        o_rd_ok
);

    localparam int AW = $clog2(DEPTH);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;
    logic        r_rd_ok;
    logic        wr_ok;
    logic        rd_ok;

    assign wr_ok = {1'b0, i_req.wr_idx} < 9'(DEPTH);
    assign rd_ok = {1'b0, i_req.rd_idx} < 9'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_ok) begin
            r_mem[i_req.wr_idx[AW-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx[AW-1:0]];
            r_rd_ok   <= rd_ok;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_ok   = r_rd_ok;

endmodule
